### rtl/dnd_pkg.sv
// Shared types and constants of the DNS name decompressor.
`default_nettype none

package dnd_pkg;

   localparam int CHAR_W     = 8;
   localparam int TEXT_AW    = 8;
   localparam int USED_W     = 10;
   localparam int COUNT_W    = 3;
   localparam int LABEL_W    = 6;

   localparam logic [1:0]        PTR_TAG   = 2'b11;
   localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
   localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'h00;

   // One character write into the text buffer.
   typedef struct packed {
      logic                valid;
      logic [TEXT_AW-1:0]  addr;
      logic [CHAR_W-1:0]   chr;
   } push_type;

   // Hand-off from the name walker to the group emitter.
   typedef struct packed {
      logic                go;
      logic                error;
      logic [TEXT_AW-1:0]  text_len;
      logic [USED_W-1:0]   used;
   } emit_cmd_type;

endpackage

`default_nettype wire

### rtl/dns_name_decompressor.sv
// Top level of the DNS name decompressor: packet store, name walker and group emitter.
`default_nettype none

// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   req_mode 0 writes req_byte_value into the packet store at req_address
//   (ignored at or beyond PACKET_BYTES); busy stays low and no result follows.
//   req_mode 1 decodes the compressed name at req_address. The walker reads
//   one packet byte per cycle through the registered read port of the packet
//   store, taking each length byte, label character and pointer byte in turn.
//   Characters land in a 256-entry text buffer; the emitter then reads it
//   back one character a cycle and presents one result per four characters.
//   A failed decode (bad offset, hop limit, overlong text) gives one result
//   with error and last set, right after the failing step.
//   Each result is shown for one cycle with rsp_valid high; the receiver
//   cannot stall it. busy stays high from the decode request until the last
//   result is registered; the next request may come while it is shown.
//   Reset (synchronous) idles the sequencer and clears rsp_valid; the packet
//   store is not cleared and holds nothing valid until written.

module dns_name_decompressor #(
   parameter int PACKET_BYTES = 512,
   parameter int MAX_HOPS     = 16,
   parameter int MAX_TEXT     = 255
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire                              req_mode,
   input  wire  [8:0]                       req_address,
   input  wire  [7:0]                       req_byte_value,
   output logic                             rsp_valid,
   output logic [dnd_pkg::CHAR_W-1:0]       rsp_char_a,
   output logic [dnd_pkg::CHAR_W-1:0]       rsp_char_b,
   output logic [dnd_pkg::CHAR_W-1:0]       rsp_char_c,
   output logic [dnd_pkg::CHAR_W-1:0]       rsp_char_d,
   output logic [dnd_pkg::COUNT_W-1:0]      rsp_char_count,
   output logic                             rsp_is_root,
   output logic [dnd_pkg::USED_W-1:0]       rsp_consumed_length,
   output logic                             rsp_error,
   output logic                             rsp_last
);

   localparam int AW = $clog2(PACKET_BYTES);
   // wide enough for a cursor plus one, a 14-bit pointer target and the offset
   localparam int XW = (AW + 1 > 15) ? AW + 1 : 15;
   localparam int LW = (AW + 2 > dnd_pkg::USED_W) ? AW + 2 : dnd_pkg::USED_W;
   localparam int HW = $clog2(MAX_HOPS + 1);
   localparam logic [XW-1:0] PB_X = XW'(PACKET_BYTES);

   typedef enum logic [1:0] {W_IDLE, W_HDR, W_PTR_LO, W_LABEL} walk_state_type;

   walk_state_type                  state_ff, state_in;
   logic [AW-1:0]                   cursor_ff, cursor_in;
   logic [AW-1:0]                   start_ff, start_in;
   logic [dnd_pkg::LABEL_W-1:0]     rem_ff, rem_in;
   logic [HW-1:0]                   hop_ff, hop_in;
   logic [dnd_pkg::TEXT_AW-1:0]     text_len_ff, text_len_in;
   logic [dnd_pkg::USED_W-1:0]      used_ff, used_in;
   logic                            fixed_ff, fixed_in;
   logic                            first_ff, first_in;
   logic [dnd_pkg::LABEL_W-1:0]     ptr_hi_ff, ptr_hi_in;
   logic [7:0]                      pkt_q_ff;
   logic [7:0]                      pkt_mem [PACKET_BYTES];

   logic                            accept;
   logic                            walk_fail;
   logic [XW-1:0]                   cursor_inc_x;
   logic                            inc_oob;
   logic [XW-1:0]                   target_x;
   logic [XW-1:0]                   start_x;
   logic [LW-1:0]                   used_base;
   logic [LW-1:0]                   used_one;
   logic [LW-1:0]                   used_two;
   logic                            text_full;
   logic                            hop_full;
   logic                            emit_busy;

   dnd_pkg::push_type               push;
   dnd_pkg::emit_cmd_type           cmd;

   assign busy   = (state_ff != W_IDLE) | emit_busy;
   assign accept = start & ~busy;

   // the shared step unit: cursor increment with its range check
   assign cursor_inc_x = XW'(cursor_ff) + XW'(1);
   assign inc_oob      = cursor_inc_x >= PB_X;
   assign target_x     = XW'({ptr_hi_ff, pkt_q_ff});
   assign start_x      = XW'(req_address);
   assign used_base    = LW'(cursor_ff) - LW'(start_ff);
   assign used_one     = used_base + LW'(1);
   assign used_two     = used_base + LW'(2);
   assign text_full    = text_len_ff >= dnd_pkg::TEXT_AW'(MAX_TEXT);
   assign hop_full     = hop_ff >= HW'(MAX_HOPS);

   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      start_in    = start_ff;
      rem_in      = rem_ff;
      hop_in      = hop_ff;
      text_len_in = text_len_ff;
      used_in     = used_ff;
      fixed_in    = fixed_ff;
      first_in    = first_ff;
      ptr_hi_in   = ptr_hi_ff;
      walk_fail   = 1'b0;
      push.valid  = 1'b0;
      push.addr   = text_len_ff;
      push.chr    = pkt_q_ff;
      cmd.go      = 1'b0;
      cmd.error   = 1'b0;
      cmd.text_len = text_len_ff;
      cmd.used    = used_ff;
      unique case (state_ff)
         W_IDLE: begin
            if (accept && req_mode) begin
               if (start_x >= PB_X) begin
                  walk_fail = 1'b1;
               end else begin
                  cursor_in   = start_x[AW-1:0];
                  start_in    = start_x[AW-1:0];
                  rem_in      = '0;
                  hop_in      = '0;
                  text_len_in = '0;
                  used_in     = '0;
                  fixed_in    = 1'b0;
                  first_in    = 1'b1;
                  state_in    = W_HDR;
               end
            end
         end
         W_HDR: begin
            if (pkt_q_ff == 8'h00) begin
               // terminator: length counts it unless a pointer fixed it
               if (!fixed_ff) begin
                  used_in = used_one[dnd_pkg::USED_W-1:0];
               end
               cmd.go   = 1'b1;
               cmd.used = used_in;
               state_in = W_IDLE;
            end else if (pkt_q_ff[7:6] == dnd_pkg::PTR_TAG) begin
               if (inc_oob || hop_full) begin
                  walk_fail = 1'b1;
               end else begin
                  hop_in = hop_ff + HW'(1);
                  if (!fixed_ff) begin
                     used_in  = used_two[dnd_pkg::USED_W-1:0];
                     fixed_in = 1'b1;
                  end
                  ptr_hi_in = pkt_q_ff[dnd_pkg::LABEL_W-1:0];
                  cursor_in = cursor_inc_x[AW-1:0];
                  state_in  = W_PTR_LO;
               end
            end else begin
               // label length byte; top bits 01 and 10 fall here too
               if ((!first_ff && text_full) || inc_oob) begin
                  walk_fail = 1'b1;
               end else begin
                  if (!first_ff) begin
                     push.valid  = 1'b1;
                     push.chr    = dnd_pkg::DOT_CHAR;
                     text_len_in = text_len_ff + 8'd1;
                  end
                  first_in  = 1'b0;
                  rem_in    = pkt_q_ff[dnd_pkg::LABEL_W-1:0];
                  cursor_in = cursor_inc_x[AW-1:0];
                  state_in  = (pkt_q_ff[dnd_pkg::LABEL_W-1:0] != '0) ? W_LABEL : W_HDR;
               end
            end
         end
         W_PTR_LO: begin
            if (target_x >= PB_X) begin
               walk_fail = 1'b1;
            end else begin
               cursor_in = target_x[AW-1:0];
               state_in  = W_HDR;
            end
         end
         W_LABEL: begin
            if (text_full || inc_oob) begin
               walk_fail = 1'b1;
            end else begin
               push.valid  = 1'b1;
               text_len_in = text_len_ff + 8'd1;
               rem_in      = rem_ff - 6'd1;
               cursor_in   = cursor_inc_x[AW-1:0];
               state_in    = (rem_ff == 6'd1) ? W_HDR : W_LABEL;
            end
         end
      endcase
      if (walk_fail) begin
         // drop the walk and hand a single error result to the emitter
         push.valid = 1'b0;
         cmd.go     = 1'b1;
         cmd.error  = 1'b1;
         state_in   = W_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cursor_ff   <= cursor_in;
      start_ff    <= start_in;
      rem_ff      <= rem_in;
      hop_ff      <= hop_in;
      text_len_ff <= text_len_in;
      used_ff     <= used_in;
      fixed_ff    <= fixed_in;
      first_ff    <= first_in;
      ptr_hi_ff   <= ptr_hi_in;
   end

   // packet store: write on a load request, read at the next cursor so the
   // byte under the cursor is ready in the following cycle
   always_ff @(posedge clock) begin
      if (accept && !req_mode && (start_x < PB_X)) begin
         pkt_mem[start_x[AW-1:0]] <= req_byte_value;
      end
      pkt_q_ff <= pkt_mem[cursor_in];
   end

   dnd_group_emitter u_emitter (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .cmd                 (cmd),
      .emit_busy           (emit_busy),
      .rsp_valid           (rsp_valid),
      .rsp_char_a          (rsp_char_a),
      .rsp_char_b          (rsp_char_b),
      .rsp_char_c          (rsp_char_c),
      .rsp_char_d          (rsp_char_d),
      .rsp_char_count      (rsp_char_count),
      .rsp_is_root         (rsp_is_root),
      .rsp_consumed_length (rsp_consumed_length),
      .rsp_error           (rsp_error),
      .rsp_last            (rsp_last)
   );

   a_hop_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != W_IDLE) |-> (hop_ff <= HW'(MAX_HOPS)))
      else $error("hop count beyond limit");

   a_no_rsp_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff != W_IDLE) |-> !rsp_valid)
      else $error("result shown while walking");

   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode) |=> (busy || rsp_valid))
      else $error("decode request left no trace");

   a_text_bound: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (text_len_ff < dnd_pkg::TEXT_AW'(MAX_TEXT)))
      else $error("text buffer overrun");

endmodule

`default_nettype wire

### rtl/dnd_group_emitter.sv
// Text buffer and four-character result emitter of the DNS name decompressor.
`default_nettype none

module dnd_group_emitter (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  dnd_pkg::push_type          push,
   input  wire  dnd_pkg::emit_cmd_type      cmd,
   output logic                             emit_busy,
   output logic                             rsp_valid,
   output logic [dnd_pkg::CHAR_W-1:0]       rsp_char_a,
   output logic [dnd_pkg::CHAR_W-1:0]       rsp_char_b,
   output logic [dnd_pkg::CHAR_W-1:0]       rsp_char_c,
   output logic [dnd_pkg::CHAR_W-1:0]       rsp_char_d,
   output logic [dnd_pkg::COUNT_W-1:0]      rsp_char_count,
   output logic                             rsp_is_root,
   output logic [dnd_pkg::USED_W-1:0]       rsp_consumed_length,
   output logic                             rsp_error,
   output logic                             rsp_last
);

   localparam int TEXT_DEPTH = 1 << dnd_pkg::TEXT_AW;

   typedef enum logic {E_IDLE, E_RUN} emit_state_type;

   emit_state_type                  state_ff, state_in;
   logic [dnd_pkg::TEXT_AW-1:0]     tidx_ff, tidx_in;
   logic [dnd_pkg::TEXT_AW-1:0]     len_ff, len_in;
   logic [dnd_pkg::USED_W-1:0]      used_ff, used_in;
   logic [dnd_pkg::CHAR_W-1:0]      a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [dnd_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [dnd_pkg::CHAR_W-1:0]      text_q_ff;
   logic [dnd_pkg::CHAR_W-1:0]      text_mem [TEXT_DEPTH];

   logic                            valid_ff, valid_in;
   logic [dnd_pkg::CHAR_W-1:0]      ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rd_ff, rd_in;
   logic [dnd_pkg::COUNT_W-1:0]     rcnt_ff, rcnt_in;
   logic                            rroot_ff, rroot_in;
   logic [dnd_pkg::USED_W-1:0]      rused_ff, rused_in;
   logic                            rerr_ff, rerr_in;
   logic                            rlast_ff, rlast_in;

   logic                            in_text;
   logic [dnd_pkg::CHAR_W-1:0]      cur_char;
   logic                            group_last;

   assign in_text    = tidx_ff < len_ff;
   assign cur_char   = in_text ? text_q_ff : dnd_pkg::ZERO_CHAR;
   assign group_last = ({1'b0, tidx_ff} + 9'd1) >= {1'b0, len_ff};

   always_comb begin
      state_in = state_ff;
      tidx_in  = tidx_ff;
      len_in   = len_ff;
      used_in  = used_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      rc_in    = rc_ff;
      rd_in    = rd_ff;
      rcnt_in  = rcnt_ff;
      rroot_in = rroot_ff;
      rused_in = rused_ff;
      rerr_in  = rerr_ff;
      rlast_in = rlast_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (cmd.go && cmd.error) begin
               // failed walk: one all-zero result with error and last
               valid_in = 1'b1;
               ra_in    = dnd_pkg::ZERO_CHAR;
               rb_in    = dnd_pkg::ZERO_CHAR;
               rc_in    = dnd_pkg::ZERO_CHAR;
               rd_in    = dnd_pkg::ZERO_CHAR;
               rcnt_in  = '0;
               rroot_in = 1'b0;
               rused_in = '0;
               rerr_in  = 1'b1;
               rlast_in = 1'b1;
            end else if (cmd.go) begin
               len_in   = cmd.text_len;
               used_in  = cmd.used;
               tidx_in  = '0;
               state_in = E_RUN;
            end
         end
         E_RUN: begin
            cnt_in  = ((tidx_ff[1:0] == 2'd0) ? 3'd0 : cnt_ff) + {2'b00, in_text};
            tidx_in = tidx_ff + 8'd1;
            unique case (tidx_ff[1:0])
               2'd0: a_in = cur_char;
               2'd1: b_in = cur_char;
               2'd2: c_in = cur_char;
               default: begin
                  valid_in = 1'b1;
                  ra_in    = a_ff;
                  rb_in    = b_ff;
                  rc_in    = c_ff;
                  rd_in    = cur_char;
                  rcnt_in  = cnt_in;
                  rroot_in = (len_ff == '0);
                  rused_in = group_last ? used_ff : '0;
                  rerr_in  = 1'b0;
                  rlast_in = group_last;
                  if (group_last) begin
                     state_in = E_IDLE;
                  end
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      tidx_ff  <= tidx_in;
      len_ff   <= len_in;
      used_ff  <= used_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      cnt_ff   <= cnt_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      rc_ff    <= rc_in;
      rd_ff    <= rd_in;
      rcnt_ff  <= rcnt_in;
      rroot_ff <= rroot_in;
      rused_ff <= rused_in;
      rerr_ff  <= rerr_in;
      rlast_ff <= rlast_in;
   end

   // text buffer: one write, one registered read addressed ahead by the next index
   always_ff @(posedge clock) begin
      if (push.valid) begin
         text_mem[push.addr] <= push.chr;
      end
      text_q_ff <= text_mem[tidx_in];
   end

   assign emit_busy           = (state_ff == E_RUN);
   assign rsp_valid           = valid_ff;
   assign rsp_char_a          = ra_ff;
   assign rsp_char_b          = rb_ff;
   assign rsp_char_c          = rc_ff;
   assign rsp_char_d          = rd_ff;
   assign rsp_char_count      = rcnt_ff;
   assign rsp_is_root         = rroot_ff;
   assign rsp_consumed_length = rused_ff;
   assign rsp_error           = rerr_ff;
   assign rsp_last            = rlast_ff;

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_last && rsp_char_count == '0 &&
                                    rsp_consumed_length == '0))
      else $error("error result carries data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_count <= 3'd4))
      else $error("character count above four");

   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on adjacent cycles");

endmodule

`default_nettype wire

### dv/dnd_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the DNS name decompressor: packet mirror, name decoder and group check.
package dnd_tb_pkg;

   import dnd_pkg::*;

   localparam int PACKET_BYTES = 512;
   localparam int MAX_HOPS     = 16;
   localparam int MAX_TEXT     = 255;

   // Top two bits of a length byte.
   localparam logic [1:0] LABEL_TAG  = 2'b00;
   localparam logic [1:0] EXT_TAG_LO = 2'b01;
   localparam logic [1:0] EXT_TAG_HI = 2'b10;

   typedef enum bit {
      MODE_WRITE  = 1'b0,
      MODE_DECODE = 1'b1
   } req_mode_t;

   typedef struct packed {
      logic [CHAR_W-1:0]  char_a;
      logic [CHAR_W-1:0]  char_b;
      logic [CHAR_W-1:0]  char_c;
      logic [CHAR_W-1:0]  char_d;
      logic [COUNT_W-1:0] char_count;
      logic               is_root;
      logic [USED_W-1:0]  consumed_length;
      logic               error;
      logic               last;
   } name_group_t;

   class name_scoreboard;
      logic [7:0]  packet [PACKET_BYTES];
      logic [7:0]  text [$];
      name_group_t expected_groups [$];
      int          failures = 0;

      function int pending();
         return expected_groups.size();
      endfunction

      function bit push_char(logic [7:0] c);
         if (text.size() >= MAX_TEXT)
            return 0;
         text.push_back(c);
         return 1;
      endfunction

      // Walk the name at origin into text; 0 on a failed decode.
      function bit walk_name(input int origin, output int used);
         int         cursor;
         int         hops;
         int         run;
         bit         ptr_seen;
         bit         first_label;
         logic [7:0] lead;
         text.delete();
         used        = 0;
         cursor      = origin;
         hops        = 0;
         ptr_seen    = 0;
         first_label = 1;
         if (cursor >= PACKET_BYTES)
            return 0;
         forever begin
            lead = packet[cursor];
            if (lead == 8'd0) begin
               if (!ptr_seen)
                  used = cursor - origin + 1;
               return 1;
            end
            if (lead[7:6] == PTR_TAG) begin
               if (cursor + 1 >= PACKET_BYTES)
                  return 0;
               if (hops >= MAX_HOPS)
                  return 0;
               hops++;
               if (!ptr_seen) begin
                  used     = cursor - origin + 2;
                  ptr_seen = 1;
               end
               cursor = {lead[5:0], packet[cursor + 1]};
               if (cursor >= PACKET_BYTES)
                  return 0;
               continue;
            end
            run = lead[5:0];
            if (!first_label && !push_char(DOT_CHAR))
               return 0;
            first_label = 0;
            for (int k = 0; k < run; k++) begin
               cursor++;
               if (cursor >= PACKET_BYTES)
                  return 0;
               if (!push_char(packet[cursor]))
                  return 0;
            end
            cursor++;
            if (cursor >= PACKET_BYTES)
               return 0;
         end
      endfunction

      function void note_request(req_mode_t mode, logic [8:0] addr, logic [7:0] value);
         int          used;
         int          groups;
         int          idx;
         int          count;
         logic [7:0]  quad [4];
         name_group_t grp;
         if (mode == MODE_WRITE) begin
            if (addr < PACKET_BYTES)
               packet[addr] = value;
            return;
         end
         if (!walk_name(addr, used)) begin
            grp       = '0;
            grp.error = 1'b1;
            grp.last  = 1'b1;
            expected_groups.push_back(grp);
            return;
         end
         groups = (text.size() + 3) / 4;
         if (groups == 0)
            groups = 1;
         for (int g = 0; g < groups; g++) begin
            count = 0;
            for (int k = 0; k < 4; k++) begin
               idx     = g * 4 + k;
               quad[k] = ZERO_CHAR;
               if (idx < text.size()) begin
                  quad[k] = text[idx];
                  count++;
               end
            end
            grp                 = '0;
            grp.char_a          = quad[0];
            grp.char_b          = quad[1];
            grp.char_c          = quad[2];
            grp.char_d          = quad[3];
            grp.char_count      = COUNT_W'(count);
            grp.is_root         = (text.size() == 0);
            grp.last            = (g == groups - 1);
            grp.consumed_length = grp.last ? USED_W'(used) : '0;
            expected_groups.push_back(grp);
         end
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_group(name_group_t got);
         name_group_t want;
         if (expected_groups.size() == 0) begin
            $error("group with no decode pending: count %0d last %0b error %0b",
                   got.char_count, got.last, got.error);
            failures++;
            return;
         end
         want = expected_groups.pop_front();
         compare_field("char_a", want.char_a, got.char_a);
         compare_field("char_b", want.char_b, got.char_b);
         compare_field("char_c", want.char_c, got.char_c);
         compare_field("char_d", want.char_d, got.char_d);
         compare_field("char_count", want.char_count, got.char_count);
         compare_field("is_root", want.is_root, got.is_root);
         compare_field("consumed_length", want.consumed_length, got.consumed_length);
         compare_field("error", want.error, got.error);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

endpackage

### dv/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench of the DNS name decompressor: packet load, directed and random decodes.
module testbench;

   import dnd_pkg::*;
   import dnd_tb_pkg::*;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_mode;
   logic [8:0]          req_address;
   logic [7:0]          req_byte_value;
   logic                rsp_valid;
   logic [CHAR_W-1:0]   rsp_char_a;
   logic [CHAR_W-1:0]   rsp_char_b;
   logic [CHAR_W-1:0]   rsp_char_c;
   logic [CHAR_W-1:0]   rsp_char_d;
   logic [COUNT_W-1:0]  rsp_char_count;
   logic                rsp_is_root;
   logic [USED_W-1:0]   rsp_consumed_length;
   logic                rsp_error;
   logic                rsp_last;

   name_scoreboard sb = new;
   name_group_t    seen_group;
   logic           steady;
   int             accepted_items;
   int             accepted_decodes;

   dns_name_decompressor u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_address         (req_address),
      .req_byte_value      (req_byte_value),
      .rsp_valid           (rsp_valid),
      .rsp_char_a          (rsp_char_a),
      .rsp_char_b          (rsp_char_b),
      .rsp_char_c          (rsp_char_c),
      .rsp_char_d          (rsp_char_d),
      .rsp_char_count      (rsp_char_count),
      .rsp_is_root         (rsp_is_root),
      .rsp_consumed_length (rsp_consumed_length),
      .rsp_error           (rsp_error),
      .rsp_last            (rsp_last)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Present one request, hold it until the edge that takes it, then idle a while.
   // A zero gap leaves start high so the next request follows back to back.
   task automatic send_request(input req_mode_t mode, input logic [8:0] addr,
                               input logic [7:0] value);
      int gap;
      int roll;
      req_mode       <= mode;
      req_address    <= addr;
      req_byte_value <= value;
      start          <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(mode, addr, value);
      accepted_items++;
      if (mode == MODE_DECODE)
         accepted_decodes++;
      // Mostly no gap or a short one, now and then a long one.
      roll = $urandom_range(0, 99);
      if (steady)
         gap = 0;
      else if (roll < 55)
         gap = 0;
      else if (roll < 90)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and hold off until every predicted group has come back.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Take each group at the edge that ends its cycle; the block cannot be stalled.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         seen_group = {rsp_char_a, rsp_char_b, rsp_char_c, rsp_char_d, rsp_char_count,
                       rsp_is_root, rsp_consumed_length, rsp_error, rsp_last};
         sb.check_group(seen_group);
      end
   end

   initial begin
      logic [7:0]  image [PACKET_BYTES];
      logic [7:0]  lead;
      logic [15:0] ptr_word;
      int          at;
      int          origin;
      int          inner;
      int          labels;
      int          run;
      int          pick;
      int          ptr_to;
      int          roll;
      int          last_origin;
      int          base_items;
      int          base_decodes;
      int          probes [16] = '{0, 1, 65, 258, 262, 264, 266, 272, 274, 276, 282,
                                   288, 290, 508, 510, 511};

      reset          <= 1'b1;
      start          <= 1'b0;
      req_mode       <= MODE_WRITE;
      req_address    <= '0;
      req_byte_value <= '0;
      steady           = 1'b0;
      accepted_items   = 0;
      accepted_decodes = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Build the packet image: random filler with the special names laid over it.
      foreach (image[i])
         image[i] = 8'($urandom_range(0, 255));
      // Root name at offset 0.
      image[0] = 8'd0;
      // Four labels of 63 random bytes: exactly the longest legal text, 257 bytes in place.
      at = 1;
      repeat (4) begin
         image[at] = {LABEL_TAG, 6'd63};
         at++;
         repeat (63) begin
            image[at] = 8'($urandom_range(0, 255));
            at++;
         end
      end
      image[257] = 8'd0;
      // One label, then a pointer to the long name: the text runs past its limit.
      {image[258], image[259], image[260], image[261]} = {8'd1, "x", PTR_TAG, 14'd1};
      // Pointer to itself: runs out of hops.
      {image[262], image[263]} = {PTR_TAG, 14'd262};
      // Pointer straight to the root: empty name, two bytes in place.
      {image[264], image[265]} = {PTR_TAG, 14'd0};
      // Label, then pointer to the root.
      {image[266], image[267], image[268], image[269], image[270], image[271]} =
         {8'd3, "abc", PTR_TAG, 14'd0};
      // Pointer target far beyond the packet.
      {image[272], image[273]} = {PTR_TAG, 14'h3FFF};
      // Pointer to the last byte, which holds the first half of another pointer.
      {image[274], image[275]} = {PTR_TAG, 14'd511};
      // Extended length byte with zero length, then a plain label.
      {image[276], image[277], image[278], image[279], image[280], image[281]} =
         {EXT_TAG_LO, 6'd0, 8'd2, "ok", 8'd0, 8'd0};
      // Length bytes tagged 01 and 10.
      {image[282], image[283], image[284], image[285], image[286], image[287]} =
         {EXT_TAG_LO, 6'd2, "hi", EXT_TAG_HI, 6'd1, "z", 8'd0};
      // Chain of exactly MAX_HOPS pointers ending at the root; one more in front of it.
      {image[288], image[289]} = {PTR_TAG, 14'd290};
      for (int i = 0; i < 15; i++)
         {image[290 + 2 * i], image[291 + 2 * i]} = {PTR_TAG, 14'(292 + 2 * i)};
      {image[320], image[321]} = {PTR_TAG, 14'd0};
      // Labels that run off the end of the packet.
      image[508] = {LABEL_TAG, 6'd5};
      image[510] = {LABEL_TAG, 6'd1};
      image[511] = {PTR_TAG, 6'd0};

      // Load every byte so that no decode can read an unwritten entry.
      for (int i = 0; i < PACKET_BYTES; i++)
         send_request(MODE_WRITE, 9'(i), image[i]);

      // Directed decodes of the special names above.
      foreach (probes[i])
         send_request(MODE_DECODE, 9'(probes[i]), 8'($urandom_range(0, 255)));
      wait_drained();

      // Random part: mostly well-formed names in the scratch area, some noise.
      last_origin  = 266;
      base_items   = accepted_items;
      base_decodes = accepted_decodes;
      while (accepted_items - base_items < 410 || accepted_decodes - base_decodes < 40) begin
         // Toggle stretches with no idling at all.
         if ($urandom_range(0, 29) == 0)
            steady = !steady;
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            // Write a name of a few labels, mostly short, now and then longer.
            origin = $urandom_range(322, 440);
            at     = origin;
            inner  = -1;
            labels = $urandom_range(1, 4);
            for (int l = 0; l < labels; l++) begin
               run = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
               if (at + run + 3 > 507)
                  break;
               if (at != origin && inner < 0)
                  inner = at;
               pick = $urandom_range(0, 9);
               if (pick == 0)
                  lead = {EXT_TAG_LO, 6'(run)};
               else if (pick == 1)
                  lead = {EXT_TAG_HI, 6'(run)};
               else
                  lead = {LABEL_TAG, 6'(run)};
               send_request(MODE_WRITE, 9'(at), lead);
               at++;
               repeat (run) begin
                  send_request(MODE_WRITE, 9'(at), 8'($urandom_range(0, 255)));
                  at++;
               end
            end
            // End with a terminator, a pointer, or nothing: then the walk runs on.
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               send_request(MODE_WRITE, 9'(at), 8'd0);
            end else if (pick < 9) begin
               case ($urandom_range(0, 6))
                  0:       ptr_to = 0;
                  1:       ptr_to = 1;
                  2:       ptr_to = 65;
                  3:       ptr_to = 266;
                  4:       ptr_to = 282;
                  5:       ptr_to = 290;
                  default: ptr_to = last_origin;
               endcase
               ptr_word = {PTR_TAG, 14'(ptr_to)};
               send_request(MODE_WRITE, 9'(at), ptr_word[15:8]);
               send_request(MODE_WRITE, 9'(at + 1), ptr_word[7:0]);
            end
            send_request(MODE_DECODE, 9'(origin), 8'($urandom_range(0, 255)));
            if (inner >= 0 && $urandom_range(0, 2) == 0)
               send_request(MODE_DECODE, 9'(inner), 8'($urandom_range(0, 255)));
            last_origin = origin;
         end else if (roll < 80) begin
            // Stray byte in the scratch area.
            send_request(MODE_WRITE, 9'($urandom_range(322, 507)), 8'($urandom_range(0, 255)));
         end else if (roll < 85) begin
            // Stray byte anywhere, the special names included.
            send_request(MODE_WRITE, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
         end else begin
            // Decode at an arbitrary offset.
            send_request(MODE_DECODE, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 39) == 0)
            wait_drained();
      end

      // Drain, then give the block time to show any group it should not.
      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.failures == 0)
         $display("** dns_name_decompressor: PASSED **");
      else
         $display("** dns_name_decompressor: FAILED **");
      $finish;
   end

   // Stop a hung run: far beyond the slowest legal run.
   initial begin
      #(20_000_000);
      $error("run did not finish in time, %0d groups still expected", sb.pending());
      $display("** dns_name_decompressor: FAILED **");
      $finish;
   end

endmodule

### filelist.f
rtl/dnd_pkg.sv
rtl/dnd_group_emitter.sv
rtl/dns_name_decompressor.sv
dv/dnd_scoreboard.sv
dv/testbench.sv
